[rtl/rowds_pkg.sv]
package rowds_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] pixel_in;
		logic       row_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       row_done;
		logic       run_last;
	} out_item_t;

	// position of the next sample within its row
	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EVEN,
		PH_ODD
	} phase_t;

	// kernel selection for one queued command
	typedef enum logic [2:0] {
		OP_PASS,
		OP_MEAN,
		OP_MID,
		OP_MID_TAIL,
		OP_TAIL134
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] p;
	} cmd_t;

endpackage

[rtl/rowds_front.sv]
module rowds_front import rowds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t sample,
	output logic     full,
	input  logic     q_full,
	output logic     q_push,
	output cmd_t     q_cmd
);

	phase_t     phase_q, phase_d;
	logic [7:0] win_q [3];
	logic [7:0] win_d [3];
	logic       accept;

	assign accept = push && !q_full;
	assign full   = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			win_q   <= win_d;
		end
	end

	always_comb begin
		q_push   = 1'b0;
		q_cmd.op = OP_PASS;
		q_cmd.a  = win_q[2];
		q_cmd.b  = win_q[1];
		q_cmd.c  = win_q[0];
		q_cmd.p  = sample.pixel_in;
		// shift by default; row start reloads the whole window
		win_d[0] = sample.pixel_in;
		win_d[1] = win_q[0];
		win_d[2] = win_q[1];
		phase_d  = phase_q;
		case (phase_q)
			PH_FIRST: begin
				q_push   = sample.row_end;
				q_cmd.op = OP_PASS;
				win_d[1] = sample.pixel_in;
				win_d[2] = sample.pixel_in;
				phase_d  = PH_SECOND;
			end
			PH_SECOND: begin
				q_push   = sample.row_end;
				q_cmd.op = OP_MEAN;
				phase_d  = PH_EVEN;
			end
			PH_EVEN: begin
				q_push   = 1'b1;
				q_cmd.op = sample.row_end ? OP_MID_TAIL : OP_MID;
				phase_d  = PH_ODD;
			end
			PH_ODD: begin
				q_push   = sample.row_end;
				q_cmd.op = OP_TAIL134;
				phase_d  = PH_EVEN;
			end
			default: begin
				phase_d = PH_FIRST;
			end
		endcase
		if (sample.row_end)
			phase_d = PH_FIRST;
		q_push = q_push && accept;
	end

endmodule

[rtl/rowds_queue.sv]
module rowds_queue import rowds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
		ptr_inc = (ptr == QPTR_W'(QDEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (rd_en)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

[rtl/rowds_back.sv]
module rowds_back import rowds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      q_cmd,
	input  logic      q_empty,
	output logic      q_pop,
	output out_item_t result,
	output logic      empty,
	input  logic      pop
);

	out_item_t   out_q, out_d;
	logic        out_valid_q;
	logic        sub_q;
	logic        load;
	logic [8:0]  sum_bc;
	logic [10:0] acc_mid, acc_17, acc_134;
	logic [8:0]  acc_mean;

	assign empty  = !out_valid_q;
	assign result = out_q;
	assign load   = (!out_valid_q || pop) && !q_empty;

	// 1,3,3,1 interior; 1,7, 1,3,4 and 1,1 row-end kernels; all round half up
	always_comb begin
		sum_bc   = {1'b0, q_cmd.b} + {1'b0, q_cmd.c};
		acc_mid  = {3'b0, q_cmd.a} + {1'b0, sum_bc, 1'b0} + {2'b0, sum_bc}
			+ {3'b0, q_cmd.p} + 11'd4;
		acc_17   = {3'b0, q_cmd.c} + {q_cmd.p, 3'b0} - {3'b0, q_cmd.p} + 11'd4;
		acc_134  = {3'b0, q_cmd.b} + {2'b0, q_cmd.c, 1'b0} + {3'b0, q_cmd.c}
			+ {1'b0, q_cmd.p, 2'b0} + 11'd4;
		acc_mean = {1'b0, q_cmd.c} + {1'b0, q_cmd.p} + 9'd1;
	end

	always_comb begin
		out_d.row_done = 1'b1;
		out_d.run_last = 1'b1;
		q_pop          = load;
		case (q_cmd.op)
			OP_PASS:     out_d.pixel_out = q_cmd.p;
			OP_MEAN:     out_d.pixel_out = acc_mean[8:1];
			OP_MID: begin
				out_d.pixel_out = acc_mid[10:3];
				out_d.row_done  = 1'b0;
			end
			OP_MID_TAIL: begin
				if (sub_q) begin
					out_d.pixel_out = acc_17[10:3];
				end else begin
					out_d.pixel_out = acc_mid[10:3];
					out_d.row_done  = 1'b0;
					out_d.run_last  = 1'b0;
					q_pop           = 1'b0;
				end
			end
			OP_TAIL134:  out_d.pixel_out = acc_134[10:3];
			default:     out_d.pixel_out = q_cmd.p;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (load)
				sub_q <= (q_cmd.op == OP_MID_TAIL) && !sub_q;
		end
	end

`ifndef SYNTHESIS
	a_sub_head: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (!q_empty && q_cmd.op == OP_MID_TAIL))
		else $error("second result pending without a two-result command");
	a_pop_whole: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_cmd.op != OP_MID_TAIL || sub_q))
		else $error("two-result command retired after one result");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.row_done) |-> out_q.run_last)
		else $error("row end result not marked as last of its item");
`endif

endmodule

[rtl/row_downsample_2x_1331.sv]
// Horizontal 2:1 row downsampler, 1,3,3,1 kernel with round half up.
//
// Input channel: one pixel per item (sample.pixel_in) with sample.row_end on
// the last pixel of a row. An item is taken on a clock edge with push high
// and full low. A row of w pixels yields ceil(w/2) results.
// Result channel: result.pixel_out, result.row_done on the final pixel of the
// row, result.run_last on the last result caused by one input item. The head
// result is valid while empty is low and is taken on an edge with pop high.
//
// Structure: a front end tracks row position and a three-pixel window and
// turns each pixel into a kernel command; a four-entry command queue feeds a
// back end that evaluates the kernel into an output register.
// Path: a pixel's command is written into the queue on the edge that takes it;
// with queue and output register empty the back end then loads its result.
// Throughput: one pixel per cycle while full is low; the last pixel of an
// odd-width row of three or more gives two results from one queued command.
// When pop stays low the output register holds, the queue fills and full
// rises; nothing is dropped. Reset clears row position, window, queue and
// output register; the first pixel after reset starts a new row.
module row_downsample_2x_1331 import rowds_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  sample,
	output logic      full,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	cmd_t fe_cmd;
	cmd_t q_head;
	logic fe_push;
	logic q_full;
	logic q_empty;
	logic q_pop;

	// front end: row position, window, command classification
	rowds_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.sample (sample),
		.full   (full),
		.q_full (q_full),
		.q_push (fe_push),
		.q_cmd  (fe_cmd)
	);

	// decouples the front end from output stalls
	rowds_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_push),
		.wr_data (fe_cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	// back end: kernel evaluation and result register
	rowds_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
